// ----- design/eulxyz_pkg.sv -----
// ----------------------------------------------------------------------------
// Euler XYZ transform package
// Widths, table geometry and the types shared by the trigonometry lanes,
// the matrix merge stage and the top level.
// ----------------------------------------------------------------------------
package eulxyz_pkg;

  localparam int SINE_TABLE_ENTRIES = 1024;
  localparam int FULL_TURN          = 46080;
  localparam int QUARTER_TURN       = 11520;
  localparam int ONE_Q14            = 16384;

  localparam int FUNC_W  = 3;
  localparam int ANGLE_W = 17;
  localparam int COORD_W = 32;
  localparam int TERM_W  = 16;
  localparam int TAB_W   = $clog2(ONE_Q14 + 1);
  localparam int IDX_W   = $clog2(SINE_TABLE_ENTRIES + 1);

  typedef logic [IDX_W-1:0] tab_idx_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] sin_v;
    logic signed [TERM_W-1:0] cos_v;
  } trig_pair_t;

  typedef struct packed {
    logic signed [TERM_W-1:0] m0;
    logic signed [TERM_W-1:0] m1;
    logic signed [TERM_W-1:0] m2;
    logic signed [TERM_W-1:0] m4;
    logic signed [TERM_W-1:0] m5;
    logic signed [TERM_W-1:0] m6;
    logic signed [TERM_W-1:0] m8;
    logic signed [TERM_W-1:0] m9;
    logic signed [TERM_W-1:0] m10;
  } rot_terms_t;

endpackage

// ----- design/eulxyz_sine_rom.sv -----
// ----------------------------------------------------------------------------
// Quarter-wave sine ROM
// Constant table of sin(k * 90deg / N) in Q1.14, built at elaboration from a
// fixed-point series, with two registered read ports.
// ----------------------------------------------------------------------------
module eulxyz_sine_rom import eulxyz_pkg::*; (
  input  logic             clk_i,
  input  tab_idx_t         addr_a_i,
  input  tab_idx_t         addr_b_i,
  output logic [TAB_W-1:0] data_a_o,
  output logic [TAB_W-1:0] data_b_o
);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int ROM_DEPTH = SINE_TABLE_ENTRIES + 1;

  typedef logic [TAB_W-1:0] rom_t [ROM_DEPTH];

  function automatic rom_t build_rom();
    rom_t              tab;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       term;
    logic signed [63:0] sum;
    logic [63:0]       rnd;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      x    = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_ENTRIES);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - $signed(term);
      if (sum < 0) begin
        sum = '0;
      end
      rnd    = (($unsigned(sum) << 14) + (64'd1 << 29)) >> 30;
      tab[k] = rnd[TAB_W-1:0];
    end
    return tab;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [TAB_W-1:0] data_a_q;
  logic [TAB_W-1:0] data_b_q;

  always_ff @(posedge clk_i) begin
    data_a_q <= SINE_ROM[addr_a_i];
    data_b_q <= SINE_ROM[addr_b_i];
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

// ----- design/eulxyz_trig_lane.sv -----
// ----------------------------------------------------------------------------
// Trigonometry lane
// Takes one held angle to its sine and cosine in Q1.14: quadrant split,
// table index by reciprocal multiply, ROM read and sign, over four stages.
// ----------------------------------------------------------------------------
module eulxyz_trig_lane import eulxyz_pkg::*; (
  input  logic                      clk_i,
  input  logic signed [ANGLE_W-1:0] angle_i,
  output trig_pair_t                trig_o
);

  localparam int TURN_W = $clog2(FULL_TURN);
  localparam int REST_W = $clog2(QUARTER_TURN);
  localparam int HALF_Q = QUARTER_TURN / 2;
  localparam longint NUM_MAX = longint'(QUARTER_TURN - 1) * SINE_TABLE_ENTRIES + HALF_Q;
  localparam int NUM_W = $clog2(NUM_MAX + 1);
  localparam longint RECIP = (longint'(1) << NUM_W) / QUARTER_TURN;
  localparam longint RECIP_N = RECIP * SINE_TABLE_ENTRIES;
  localparam longint RECIP_BIAS = RECIP * HALF_Q;
  localparam int EST_W = NUM_W + IDX_W;

  typedef struct packed {
    logic [1:0]        quad;
    logic [REST_W-1:0] rest;
  } quad_t;

  typedef struct packed {
    logic [1:0]       quad;
    tab_idx_t         est;
    logic [NUM_W-1:0] num;
  } est_t;

  function automatic quad_t split_turn(input logic [TURN_W-1:0] a);
    quad_t             res;
    logic [TURN_W-1:0] base;
    if (a >= TURN_W'(3 * QUARTER_TURN)) begin
      res.quad = 2'd3;
      base     = TURN_W'(3 * QUARTER_TURN);
    end else if (a >= TURN_W'(2 * QUARTER_TURN)) begin
      res.quad = 2'd2;
      base     = TURN_W'(2 * QUARTER_TURN);
    end else if (a >= TURN_W'(QUARTER_TURN)) begin
      res.quad = 2'd1;
      base     = TURN_W'(QUARTER_TURN);
    end else begin
      res.quad = 2'd0;
      base     = '0;
    end
    res.rest = REST_W'(a - base);
    return res;
  endfunction

  function automatic est_t estimate(input quad_t qr);
    est_t             res;
    logic [EST_W-1:0] prod;
    prod     = EST_W'(qr.rest) * EST_W'(RECIP_N) + EST_W'(RECIP_BIAS);
    res.quad = qr.quad;
    res.est  = prod[EST_W-1 -: IDX_W];
    res.num  = NUM_W'(qr.rest) * NUM_W'(SINE_TABLE_ENTRIES) + NUM_W'(HALF_Q);
    return res;
  endfunction

  function automatic tab_idx_t table_addr(input est_t e);
    logic [NUM_W-1:0] rem;
    tab_idx_t         idx;
    rem = e.num - NUM_W'(e.est) * NUM_W'(QUARTER_TURN);
    idx = (rem >= NUM_W'(QUARTER_TURN)) ? e.est + 1'b1 : e.est;
    return e.quad[0] ? IDX_W'(SINE_TABLE_ENTRIES) - idx : idx;
  endfunction

  logic [TURN_W-1:0]        ang_n;
  logic [TURN_W-1:0]        ang_c;
  logic [TURN_W:0]          ang_c_ext;
  quad_t                    s1_sin_q;
  quad_t                    s1_cos_q;
  est_t                     s2_sin_q;
  est_t                     s2_cos_q;
  logic                     s3_sin_neg_q;
  logic                     s3_cos_neg_q;
  tab_idx_t                 addr_sin;
  tab_idx_t                 addr_cos;
  logic [TAB_W-1:0]         mag_sin;
  logic [TAB_W-1:0]         mag_cos;
  logic signed [TERM_W-1:0] sin_mag;
  logic signed [TERM_W-1:0] cos_mag;
  trig_pair_t               trig_q;

  always_comb begin
    ang_n = angle_i[ANGLE_W-1] ? TURN_W'(angle_i + ANGLE_W'(FULL_TURN)) : TURN_W'(angle_i);
    ang_c_ext = {1'b0, ang_n} + (TURN_W + 1)'(QUARTER_TURN);
    if (ang_c_ext >= (TURN_W + 1)'(FULL_TURN)) begin
      ang_c = TURN_W'(ang_c_ext - (TURN_W + 1)'(FULL_TURN));
    end else begin
      ang_c = TURN_W'(ang_c_ext);
    end
  end

  assign addr_sin = table_addr(s2_sin_q);
  assign addr_cos = table_addr(s2_cos_q);
  assign sin_mag  = $signed(TERM_W'(mag_sin));
  assign cos_mag  = $signed(TERM_W'(mag_cos));

  eulxyz_sine_rom u_rom (
    .clk_i    (clk_i),
    .addr_a_i (addr_sin),
    .addr_b_i (addr_cos),
    .data_a_o (mag_sin),
    .data_b_o (mag_cos)
  );

  always_ff @(posedge clk_i) begin
    s1_sin_q     <= split_turn(ang_n);
    s1_cos_q     <= split_turn(ang_c);
    s2_sin_q     <= estimate(s1_sin_q);
    s2_cos_q     <= estimate(s1_cos_q);
    s3_sin_neg_q <= s2_sin_q.quad[1];
    s3_cos_neg_q <= s2_cos_q.quad[1];
    trig_q.sin_v <= s3_sin_neg_q ? -sin_mag : sin_mag;
    trig_q.cos_v <= s3_cos_neg_q ? -cos_mag : cos_mag;
  end

  assign trig_o = trig_q;

endmodule

// ----- design/eulxyz_matrix_merge.sv -----
// ----------------------------------------------------------------------------
// Rotation matrix merge
// Combines the three lanes' sines and cosines into the nine rotation terms:
// pair products, triple products, sums, then rounding to Q1.14.
// ----------------------------------------------------------------------------
module eulxyz_matrix_merge import eulxyz_pkg::*; (
  input  logic       clk_i,
  input  trig_pair_t trig_x_i,
  input  trig_pair_t trig_y_i,
  input  trig_pair_t trig_z_i,
  output rot_terms_t rot_o
);

  localparam int PAIR_W   = 2 * TERM_W;
  localparam int TRIPLE_W = PAIR_W + TERM_W;
  localparam int FRAC_W   = $clog2(ONE_Q14);
  localparam logic signed [TRIPLE_W-1:0] SAT_HI = TRIPLE_W'(ONE_Q14);
  localparam logic signed [TRIPLE_W-1:0] SAT_LO = -SAT_HI;

  function automatic logic signed [TERM_W-1:0] round_sat(
    input logic signed [TRIPLE_W-1:0] v,
    input int unsigned                sh
  );
    logic signed [TRIPLE_W-1:0] r;
    r = (v + $signed(TRIPLE_W'(1) << (sh - 1))) >>> sh;
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return r[TERM_W-1:0];
  endfunction

  logic signed [PAIR_W-1:0]   ce_q, cf_q, bd_q, ad_q, bc_q, ac_q, af_q, ae_q, bf_q, be_q;
  logic signed [TERM_W-1:0]   d1_q, e1_q, f1_q;
  logic signed [TRIPLE_W-1:0] bde_q, bdf_q, ade_q, adf_q;
  logic signed [PAIR_W-1:0]   ce2_q, cf2_q, bc2_q, ac2_q, af2_q, ae2_q, bf2_q, be2_q;
  logic signed [TERM_W-1:0]   d2_q, d3_q;
  logic signed [PAIR_W-1:0]   s0_q, s1_q, s6_q, s10_q;
  logic signed [TRIPLE_W-1:0] s4_q, s5_q, s8_q, s9_q;

  always_ff @(posedge clk_i) begin
    ce_q  <= trig_y_i.cos_v * trig_z_i.cos_v;
    cf_q  <= trig_y_i.cos_v * trig_z_i.sin_v;
    bd_q  <= trig_x_i.sin_v * trig_y_i.sin_v;
    ad_q  <= trig_x_i.cos_v * trig_y_i.sin_v;
    bc_q  <= trig_x_i.sin_v * trig_y_i.cos_v;
    ac_q  <= trig_x_i.cos_v * trig_y_i.cos_v;
    af_q  <= trig_x_i.cos_v * trig_z_i.sin_v;
    ae_q  <= trig_x_i.cos_v * trig_z_i.cos_v;
    bf_q  <= trig_x_i.sin_v * trig_z_i.sin_v;
    be_q  <= trig_x_i.sin_v * trig_z_i.cos_v;
    d1_q  <= trig_y_i.sin_v;
    e1_q  <= trig_z_i.cos_v;
    f1_q  <= trig_z_i.sin_v;

    bde_q <= bd_q * e1_q;
    bdf_q <= bd_q * f1_q;
    ade_q <= ad_q * e1_q;
    adf_q <= ad_q * f1_q;
    ce2_q <= ce_q;
    cf2_q <= cf_q;
    bc2_q <= bc_q;
    ac2_q <= ac_q;
    af2_q <= af_q;
    ae2_q <= ae_q;
    bf2_q <= bf_q;
    be2_q <= be_q;
    d2_q  <= d1_q;

    s0_q  <= ce2_q;
    s1_q  <= -cf2_q;
    s6_q  <= -bc2_q;
    s10_q <= ac2_q;
    s4_q  <= (TRIPLE_W'(af2_q) <<< FRAC_W) + bde_q;
    s5_q  <= (TRIPLE_W'(ae2_q) <<< FRAC_W) - bdf_q;
    s8_q  <= (TRIPLE_W'(bf2_q) <<< FRAC_W) - ade_q;
    s9_q  <= (TRIPLE_W'(be2_q) <<< FRAC_W) + adf_q;
    d3_q  <= d2_q;
  end

  always_comb begin
    rot_o.m0  = round_sat(TRIPLE_W'(s0_q), FRAC_W);
    rot_o.m1  = round_sat(TRIPLE_W'(s1_q), FRAC_W);
    rot_o.m2  = d3_q;
    rot_o.m4  = round_sat(s4_q, 2 * FRAC_W);
    rot_o.m5  = round_sat(s5_q, 2 * FRAC_W);
    rot_o.m6  = round_sat(TRIPLE_W'(s6_q), FRAC_W);
    rot_o.m8  = round_sat(s8_q, 2 * FRAC_W);
    rot_o.m9  = round_sat(s9_q, 2 * FRAC_W);
    rot_o.m10 = round_sat(TRIPLE_W'(s10_q), FRAC_W);
  end

endmodule

// ----- design/euler_xyz_rotation_transform_top.sv -----
// ----------------------------------------------------------------------------
// Euler XYZ rotation transform
// Holds three Euler angles and a position and returns, for every input item,
// the X-then-Y-then-Z rotation terms in Q1.14 and the position in Q16.16.
// Both channels use valid and ready; func selects rotate, translate or a
// coordinate set, and unused codes leave the state as it is.
// An item is taken by the held state at the edge that accepts it; its result
// reaches the output register through the four stages of each trigonometry
// lane (two of them the index and ROM read) and the three stages of the matrix
// merge. One item is in work at a time: the block takes no new item until the
// result of the last one is loaded into the output register.
// A result waits in the output register while the receiver stalls; the next
// item is still accepted, and its result is held in the pipeline until the
// output register is free.
// Reset clears the angles, the position and the handshake state. The sine
// table is a constant ROM and needs no clearing pass.
// ----------------------------------------------------------------------------
module euler_xyz_rotation_transform_top import eulxyz_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [FUNC_W-1:0]         func_i,
  input  logic signed [ANGLE_W-1:0] delta_angle_x_i,
  input  logic signed [ANGLE_W-1:0] delta_angle_y_i,
  input  logic signed [ANGLE_W-1:0] delta_angle_z_i,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_z_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [TERM_W-1:0]  rot_m0_o,
  output logic signed [TERM_W-1:0]  rot_m1_o,
  output logic signed [TERM_W-1:0]  rot_m2_o,
  output logic signed [TERM_W-1:0]  rot_m4_o,
  output logic signed [TERM_W-1:0]  rot_m5_o,
  output logic signed [TERM_W-1:0]  rot_m6_o,
  output logic signed [TERM_W-1:0]  rot_m8_o,
  output logic signed [TERM_W-1:0]  rot_m9_o,
  output logic signed [TERM_W-1:0]  rot_m10_o,
  output logic signed [COORD_W-1:0] pos_x_o,
  output logic signed [COORD_W-1:0] pos_y_o,
  output logic signed [COORD_W-1:0] pos_z_o
);

  localparam logic [FUNC_W-1:0] FUNC_ROTATE    = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FUNC_TRANSLATE = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FUNC_SET_X     = FUNC_W'(2);
  localparam logic [FUNC_W-1:0] FUNC_SET_Y     = FUNC_W'(3);
  localparam logic [FUNC_W-1:0] FUNC_SET_Z     = FUNC_W'(4);

  localparam int PIPE_DEPTH = 7;
  localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);
  localparam int SUM_W      = ANGLE_W + 1;
  localparam logic signed [SUM_W-1:0] TURN_S      = SUM_W'(FULL_TURN);
  localparam logic signed [SUM_W-1:0] TWO_TURNS_S = SUM_W'(2 * FULL_TURN);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  function automatic logic signed [ANGLE_W-1:0] wrap_angle(
    input logic signed [ANGLE_W-1:0] held,
    input logic signed [ANGLE_W-1:0] delta
  );
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] r;
    s = SUM_W'(held) + SUM_W'(delta);
    if (s >= TWO_TURNS_S) begin
      r = s - TWO_TURNS_S;
    end else if (s >= TURN_S) begin
      r = s - TURN_S;
    end else if (s <= -TWO_TURNS_S) begin
      r = s + TWO_TURNS_S;
    end else if (s <= -TURN_S) begin
      r = s + TURN_S;
    end else begin
      r = s;
    end
    return r[ANGLE_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_add(
    input logic signed [COORD_W-1:0] held,
    input logic signed [COORD_W-1:0] delta
  );
    logic signed [COORD_W:0]   s;
    logic signed [COORD_W-1:0] r;
    s = (COORD_W + 1)'(held) + (COORD_W + 1)'(delta);
    if (s[COORD_W] != s[COORD_W-1]) begin
      r = s[COORD_W] ? {1'b1, {(COORD_W - 1){1'b0}}} : {1'b0, {(COORD_W - 1){1'b1}}};
    end else begin
      r = s[COORD_W-1:0];
    end
    return r;
  endfunction

  state_e                    state_q, state_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      out_valid_q, out_valid_d;
  logic                      accept;
  logic                      load;
  logic                      out_free;

  logic signed [ANGLE_W-1:0] angle_x_q, angle_x_d;
  logic signed [ANGLE_W-1:0] angle_y_q, angle_y_d;
  logic signed [ANGLE_W-1:0] angle_z_q, angle_z_d;
  logic signed [COORD_W-1:0] pos_x_q, pos_x_d;
  logic signed [COORD_W-1:0] pos_y_q, pos_y_d;
  logic signed [COORD_W-1:0] pos_z_q, pos_z_d;

  trig_pair_t                trig_x;
  trig_pair_t                trig_y;
  trig_pair_t                trig_z;
  rot_terms_t                rot_terms;
  rot_terms_t                rot_q;
  logic signed [COORD_W-1:0] pos_out_x_q;
  logic signed [COORD_W-1:0] pos_out_y_q;
  logic signed [COORD_W-1:0] pos_out_z_q;

  always_comb begin
    out_free    = !out_valid_q || out_ready_i;
    load        = (state_q == ST_RUN) && (cnt_q == CNT_W'(PIPE_DEPTH)) && out_free;
    in_ready_o  = (state_q == ST_IDLE) || load;
    accept      = in_valid_i && in_ready_o;

    state_d = state_q;
    cnt_d   = cnt_q;
    if (accept) begin
      state_d = ST_RUN;
      cnt_d   = '0;
    end else if (load) begin
      state_d = ST_IDLE;
    end else if ((state_q == ST_RUN) && (cnt_q != CNT_W'(PIPE_DEPTH))) begin
      cnt_d = cnt_q + 1'b1;
    end

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_comb begin
    angle_x_d = angle_x_q;
    angle_y_d = angle_y_q;
    angle_z_d = angle_z_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    pos_z_d   = pos_z_q;
    if (accept) begin
      case (func_i)
        FUNC_ROTATE: begin
          angle_x_d = wrap_angle(angle_x_q, delta_angle_x_i);
          angle_y_d = wrap_angle(angle_y_q, delta_angle_y_i);
          angle_z_d = wrap_angle(angle_z_q, delta_angle_z_i);
        end
        FUNC_TRANSLATE: begin
          pos_x_d = sat_add(pos_x_q, coord_x_i);
          pos_y_d = sat_add(pos_y_q, coord_y_i);
          pos_z_d = sat_add(pos_z_q, coord_z_i);
        end
        FUNC_SET_X: begin
          pos_x_d = coord_x_i;
        end
        FUNC_SET_Y: begin
          pos_y_d = coord_y_i;
        end
        FUNC_SET_Z: begin
          pos_z_d = coord_z_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_x_q <= '0;
      angle_y_q <= '0;
      angle_z_q <= '0;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      pos_z_q   <= '0;
    end else begin
      angle_x_q <= angle_x_d;
      angle_y_q <= angle_y_d;
      angle_z_q <= angle_z_d;
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      pos_z_q   <= pos_z_d;
    end
  end

  eulxyz_trig_lane u_lane_x (
    .clk_i   (clk_i),
    .angle_i (angle_x_q),
    .trig_o  (trig_x)
  );

  eulxyz_trig_lane u_lane_y (
    .clk_i   (clk_i),
    .angle_i (angle_y_q),
    .trig_o  (trig_y)
  );

  eulxyz_trig_lane u_lane_z (
    .clk_i   (clk_i),
    .angle_i (angle_z_q),
    .trig_o  (trig_z)
  );

  eulxyz_matrix_merge u_merge (
    .clk_i    (clk_i),
    .trig_x_i (trig_x),
    .trig_y_i (trig_y),
    .trig_z_i (trig_z),
    .rot_o    (rot_terms)
  );

  always_ff @(posedge clk_i) begin
    if (load) begin
      rot_q       <= rot_terms;
      pos_out_x_q <= pos_x_q;
      pos_out_y_q <= pos_y_q;
      pos_out_z_q <= pos_z_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rot_m0_o    = rot_q.m0;
  assign rot_m1_o    = rot_q.m1;
  assign rot_m2_o    = rot_q.m2;
  assign rot_m4_o    = rot_q.m4;
  assign rot_m5_o    = rot_q.m5;
  assign rot_m6_o    = rot_q.m6;
  assign rot_m8_o    = rot_q.m8;
  assign rot_m9_o    = rot_q.m9;
  assign rot_m10_o   = rot_q.m10;
  assign pos_x_o     = pos_out_x_q;
  assign pos_y_o     = pos_out_y_q;
  assign pos_z_o     = pos_out_z_q;

`ifndef SYNTHESIS
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (angle_x_q > -FULL_TURN) && (angle_x_q < FULL_TURN) &&
    (angle_y_q > -FULL_TURN) && (angle_y_q < FULL_TURN) &&
    (angle_z_q > -FULL_TURN) && (angle_z_q < FULL_TURN))
    else $error("Held angle has left the open range of one full turn.");

  a_state_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && !accept) |=>
      ($stable(angle_x_q) && $stable(angle_y_q) && $stable(angle_z_q) &&
       $stable(pos_x_q) && $stable(pos_y_q) && $stable(pos_z_q)))
    else $error("Held state changed while an item was in work.");

  a_term_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((rot_m4_o >= -ONE_Q14) && (rot_m4_o <= ONE_Q14) &&
       (rot_m5_o >= -ONE_Q14) && (rot_m5_o <= ONE_Q14) &&
       (rot_m8_o >= -ONE_Q14) && (rot_m8_o <= ONE_Q14) &&
       (rot_m9_o >= -ONE_Q14) && (rot_m9_o <= ONE_Q14)))
    else $error("Rotation term outside the Q1.14 unit range.");
`endif

endmodule

// ----- dv/euler_xyz_rotation_transform_top_tb.sv -----
// ----------------------------------------------------------------------------
// Euler XYZ rotation transform testbench
// Drives rotate, translate, set and unused commands into the block with random
// gaps on both sides, predicts the rotation terms and the held position of
// every item and compares each returned item with the oldest prediction.
// ----------------------------------------------------------------------------
module euler_xyz_rotation_transform_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eulxyz_pkg::*;

  localparam logic [FUNC_W-1:0] FN_ROTATE    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_TRANSLATE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SET_X     = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SET_Y     = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SET_Z     = 3'd4;
  localparam logic [FUNC_W-1:0] FN_RSVD5     = 3'd5;
  localparam logic [FUNC_W-1:0] FN_RSVD6     = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD7     = 3'd7;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int ANGLE_MAX     = FULL_TURN - 1;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int IDLE_LIMIT    = 5000;
  localparam int LONG_HOLD     = 400;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  typedef struct {
    logic [FUNC_W-1:0]         func;
    logic signed [ANGLE_W-1:0] dax, day, daz;
    logic signed [COORD_W-1:0] cx, cy, cz;
    int unsigned               gap;
    bit                        drain;
  } xform_cmd_t;

  typedef struct {
    rot_terms_t                rot;
    logic signed [COORD_W-1:0] x, y, z;
  } pose_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                      in_valid_i      = 1'b0;
  logic                      in_ready_o;
  logic [FUNC_W-1:0]         func_i          = '0;
  logic signed [ANGLE_W-1:0] delta_angle_x_i = '0;
  logic signed [ANGLE_W-1:0] delta_angle_y_i = '0;
  logic signed [ANGLE_W-1:0] delta_angle_z_i = '0;
  logic signed [COORD_W-1:0] coord_x_i       = '0;
  logic signed [COORD_W-1:0] coord_y_i       = '0;
  logic signed [COORD_W-1:0] coord_z_i       = '0;
  logic                      out_valid_o;
  logic                      out_ready_i     = 1'b0;
  logic signed [TERM_W-1:0]  rot_m0_o, rot_m1_o, rot_m2_o, rot_m4_o, rot_m5_o;
  logic signed [TERM_W-1:0]  rot_m6_o, rot_m8_o, rot_m9_o, rot_m10_o;
  logic signed [COORD_W-1:0] pos_x_o, pos_y_o, pos_z_o;

  xform_cmd_t cmd_q[$];
  pose_t      pose_q[$];
  xform_cmd_t cur_cmd;

  int sine_q14[0:SINE_TABLE_ENTRIES];
  logic signed [ANGLE_W-1:0] ang_x = '0, ang_y = '0, ang_z = '0;
  logic signed [COORD_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;

  int unsigned tx_gap   = 0;
  int unsigned rx_wait  = 0;
  int unsigned rx_count = 0;
  int unsigned idle_cnt = 0;
  int unsigned errors   = 0;

  euler_xyz_rotation_transform_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .delta_angle_x_i(delta_angle_x_i),
    .delta_angle_y_i(delta_angle_y_i),
    .delta_angle_z_i(delta_angle_z_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .coord_z_i      (coord_z_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .rot_m0_o       (rot_m0_o),
    .rot_m1_o       (rot_m1_o),
    .rot_m2_o       (rot_m2_o),
    .rot_m4_o       (rot_m4_o),
    .rot_m5_o       (rot_m5_o),
    .rot_m6_o       (rot_m6_o),
    .rot_m8_o       (rot_m8_o),
    .rot_m9_o       (rot_m9_o),
    .rot_m10_o      (rot_m10_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The quarter-wave table is built from a fixed-point Taylor series of sine.
  function automatic void build_sine_table();
    logic [63:0] x, x2, term;
    longint      sum;
    for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
      x    = (64'(k) * HALF_PI_Q30) / SINE_TABLE_ENTRIES;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int i = 1; i <= 7; i++) begin
        term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
        if (i % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      sine_q14[k] = int'(((sum << 14) + (longint'(1) << 29)) >>> 30);
    end
  endfunction

  function automatic longint sin_q14(int a);
    int q, r, i;
    if (a < 0) a = a + FULL_TURN;
    q = a / QUARTER_TURN;
    r = a % QUARTER_TURN;
    i = (2 * r * SINE_TABLE_ENTRIES + QUARTER_TURN) / (2 * QUARTER_TURN);
    if (i > SINE_TABLE_ENTRIES) i = SINE_TABLE_ENTRIES;
    case (q)
      0:       return  sine_q14[i];
      1:       return  sine_q14[SINE_TABLE_ENTRIES - i];
      2:       return -sine_q14[i];
      default: return -sine_q14[SINE_TABLE_ENTRIES - i];
    endcase
  endfunction

  function automatic longint cos_q14(int a);
    int b;
    b = a + QUARTER_TURN;
    if (b >= FULL_TURN) b = b - FULL_TURN;
    return sin_q14(b);
  endfunction

  function automatic logic signed [TERM_W-1:0] round_q14(longint v, int sh);
    longint r;
    r = (v + (longint'(1) << (sh - 1))) >>> sh;
    if (r > ONE_Q14) r = ONE_Q14;
    if (r < -ONE_Q14) r = -ONE_Q14;
    return r[TERM_W-1:0];
  endfunction

  function automatic logic signed [ANGLE_W-1:0] wrap_angle(
      logic signed [ANGLE_W-1:0] held, logic signed [ANGLE_W-1:0] delta);
    longint s;
    s = (longint'(held) + longint'(delta)) % FULL_TURN;
    return s[ANGLE_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_add(
      logic signed [COORD_W-1:0] a, logic signed [COORD_W-1:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > longint'(COORD_MAX)) s = longint'(COORD_MAX);
    if (s < longint'(COORD_MIN)) s = longint'(COORD_MIN);
    return s[COORD_W-1:0];
  endfunction

  function automatic pose_t advance_pose(xform_cmd_t c);
    pose_t  p;
    longint cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;
    case (c.func)
      FN_ROTATE: begin
        ang_x = wrap_angle(ang_x, c.dax);
        ang_y = wrap_angle(ang_y, c.day);
        ang_z = wrap_angle(ang_z, c.daz);
      end
      FN_TRANSLATE: begin
        pos_x = sat_add(pos_x, c.cx);
        pos_y = sat_add(pos_y, c.cy);
        pos_z = sat_add(pos_z, c.cz);
      end
      FN_SET_X: pos_x = c.cx;
      FN_SET_Y: pos_y = c.cy;
      FN_SET_Z: pos_z = c.cz;
      default: ;
    endcase
    cos_x = cos_q14(int'(ang_x));
    sin_x = sin_q14(int'(ang_x));
    cos_y = cos_q14(int'(ang_y));
    sin_y = sin_q14(int'(ang_y));
    cos_z = cos_q14(int'(ang_z));
    sin_z = sin_q14(int'(ang_z));
    p.rot.m0  = round_q14(cos_y * cos_z, 14);
    p.rot.m1  = round_q14(-(cos_y * sin_z), 14);
    p.rot.m2  = sin_y[TERM_W-1:0];
    p.rot.m4  = round_q14(sin_x * sin_y * cos_z + cos_x * sin_z * ONE_Q14, 28);
    p.rot.m5  = round_q14(-(sin_x * sin_y * sin_z) + cos_x * cos_z * ONE_Q14, 28);
    p.rot.m6  = round_q14(-(sin_x * cos_y), 14);
    p.rot.m8  = round_q14(-(cos_x * sin_y * cos_z) + sin_x * sin_z * ONE_Q14, 28);
    p.rot.m9  = round_q14(cos_x * sin_y * sin_z + sin_x * cos_z * ONE_Q14, 28);
    p.rot.m10 = round_q14(cos_x * cos_y, 14);
    p.x = pos_x;
    p.y = pos_y;
    p.z = pos_z;
    return p;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] rand_delta();
    case ($urandom_range(0, 9))
      0: return ANGLE_W'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: return ANGLE_W'(ANGLE_MAX);
          1: return ANGLE_W'(-ANGLE_MAX);
          2: return 17'sh10000;
          3: return 17'sh0ffff;
          default: return '0;
        endcase
      end
      2, 3: return ANGLE_W'(int'($urandom_range(0, 512)) - 256);
      default: return ANGLE_W'(int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX);
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return COORD_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic void push_cmd(logic [FUNC_W-1:0] func,
      logic signed [ANGLE_W-1:0] dax, logic signed [ANGLE_W-1:0] day,
      logic signed [ANGLE_W-1:0] daz, logic signed [COORD_W-1:0] cx,
      logic signed [COORD_W-1:0] cy, logic signed [COORD_W-1:0] cz,
      int unsigned gap, bit drain);
    xform_cmd_t c;
    c.func  = func;
    c.dax   = dax;
    c.day   = day;
    c.daz   = daz;
    c.cx    = cx;
    c.cy    = cy;
    c.cz    = cz;
    c.gap   = gap;
    c.drain = drain;
    cmd_q.push_back(c);
  endfunction

  task automatic check_term(string what, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic launch;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_gap     <= 0;
    end else begin
      launch = 1'b0;
      if (in_valid_i && in_ready_o) pose_q.push_back(advance_pose(cur_cmd));
      if ((!in_valid_i || in_ready_o) && cmd_q.size() != 0) begin
        if (tx_gap < cmd_q[0].gap) begin
          tx_gap <= tx_gap + 1;
        end else if (!cmd_q[0].drain || pose_q.size() == 0) begin
          cur_cmd         = cmd_q.pop_front();
          launch          = 1'b1;
          tx_gap          <= 0;
          func_i          <= cur_cmd.func;
          delta_angle_x_i <= cur_cmd.dax;
          delta_angle_y_i <= cur_cmd.day;
          delta_angle_z_i <= cur_cmd.daz;
          coord_x_i       <= cur_cmd.cx;
          coord_y_i       <= cur_cmd.cy;
          coord_z_i       <= cur_cmd.cz;
        end
      end
      in_valid_i <= launch || (in_valid_i && !in_ready_o);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pose_t       want;
    int unsigned nxt;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_wait     <= 0;
    end else begin
      nxt = rx_wait;
      if (out_valid_o && out_ready_i) begin
        if (pose_q.size() == 0) begin
          errors++;
          $display("%0t: item returned with no prediction waiting", $time);
        end else begin
          want = pose_q.pop_front();
          check_term("rot_m0", $signed(want.rot.m0), rot_m0_o);
          check_term("rot_m1", $signed(want.rot.m1), rot_m1_o);
          check_term("rot_m2", $signed(want.rot.m2), rot_m2_o);
          check_term("rot_m4", $signed(want.rot.m4), rot_m4_o);
          check_term("rot_m5", $signed(want.rot.m5), rot_m5_o);
          check_term("rot_m6", $signed(want.rot.m6), rot_m6_o);
          check_term("rot_m8", $signed(want.rot.m8), rot_m8_o);
          check_term("rot_m9", $signed(want.rot.m9), rot_m9_o);
          check_term("rot_m10", $signed(want.rot.m10), rot_m10_o);
          check_term("pos_x", want.x, pos_x_o);
          check_term("pos_y", want.y, pos_y_o);
          check_term("pos_z", want.z, pos_z_o);
        end
        rx_count++;
        if (rx_count % 400 == 250) begin
          nxt = LONG_HOLD;
        end else if ((rx_count / 50) % 3 == 1) begin
          nxt = 0;
        end else begin
          nxt = $urandom_range(0, 7);
        end
      end else if (nxt != 0) begin
        nxt--;
      end
      rx_wait     <= nxt;
      out_ready_i <= (nxt == 0);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cnt <= 0;
      end else if (idle_cnt >= IDLE_LIMIT) begin
        $display("[euler_xyz_rotation_transform_top] ERROR");
        $finish;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  initial begin : stimulus
    logic [FUNC_W-1:0] func;
    int unsigned       gap;
    build_sine_table();

    // Unused codes first, while the state is still the reset state.
    push_cmd(FN_RSVD5, rand_delta(), rand_delta(), rand_delta(),
             rand_coord(), rand_coord(), rand_coord(), 0, 1'b0);
    push_cmd(FN_RSVD6, rand_delta(), rand_delta(), rand_delta(),
             rand_coord(), rand_coord(), rand_coord(), 1, 1'b0);
    push_cmd(FN_RSVD7, rand_delta(), rand_delta(), rand_delta(),
             rand_coord(), rand_coord(), rand_coord(), 0, 1'b0);
    push_cmd(FN_ROTATE, '0, '0, '0, rand_coord(), rand_coord(), rand_coord(), 2, 1'b0);
    push_cmd(FN_ROTATE, ANGLE_W'(QUARTER_TURN), ANGLE_W'(2 * QUARTER_TURN),
             ANGLE_W'(3 * QUARTER_TURN), rand_coord(), rand_coord(), rand_coord(), 0, 1'b0);
    push_cmd(FN_ROTATE, ANGLE_W'(ANGLE_MAX), ANGLE_W'(-ANGLE_MAX), 17'sd1,
             rand_coord(), rand_coord(), rand_coord(), 0, 1'b0);
    push_cmd(FN_ROTATE, ANGLE_W'(-ANGLE_MAX), ANGLE_W'(ANGLE_MAX), -17'sd1,
             rand_coord(), rand_coord(), rand_coord(), 3, 1'b0);
    // Increments beyond one full turn, the widest values the port can carry.
    push_cmd(FN_ROTATE, 17'sh0ffff, 17'sh10000, 17'sh0ffff,
             rand_coord(), rand_coord(), rand_coord(), 0, 1'b0);
    push_cmd(FN_ROTATE, 17'sh10000, 17'sh0ffff, 17'sh10000,
             rand_coord(), rand_coord(), rand_coord(), 0, 1'b0);
    push_cmd(FN_ROTATE, 17'sd64, -17'sd64, 17'sd1,
             rand_coord(), rand_coord(), rand_coord(), 5, 1'b0);
    push_cmd(FN_SET_X, rand_delta(), rand_delta(), rand_delta(),
             COORD_MAX, rand_coord(), rand_coord(), 0, 1'b0);
    push_cmd(FN_SET_Y, rand_delta(), rand_delta(), rand_delta(),
             rand_coord(), COORD_MIN, rand_coord(), 0, 1'b0);
    push_cmd(FN_SET_Z, rand_delta(), rand_delta(), rand_delta(),
             rand_coord(), rand_coord(), COORD_MAX, 7, 1'b0);
    // Saturation at both ends of the position range.
    push_cmd(FN_TRANSLATE, rand_delta(), rand_delta(), rand_delta(),
             32'sd1, -32'sd1, COORD_MAX, 0, 1'b0);
    push_cmd(FN_TRANSLATE, rand_delta(), rand_delta(), rand_delta(),
             COORD_MIN, COORD_MAX, COORD_MIN, 0, 1'b0);
    push_cmd(FN_TRANSLATE, rand_delta(), rand_delta(), rand_delta(),
             '1, '1, '1, 1, 1'b0);
    push_cmd(FN_SET_X, rand_delta(), rand_delta(), rand_delta(),
             '0, rand_coord(), rand_coord(), 0, 1'b0);
    push_cmd(FN_SET_Y, rand_delta(), rand_delta(), rand_delta(),
             rand_coord(), '1, rand_coord(), 0, 1'b0);
    push_cmd(FN_SET_Z, rand_delta(), rand_delta(), rand_delta(),
             rand_coord(), rand_coord(), COORD_MIN, 0, 1'b0);
    push_cmd(FN_TRANSLATE, rand_delta(), rand_delta(), rand_delta(),
             COORD_MIN, COORD_MIN, COORD_MIN, 4, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 99)) inside
        [0:39]:  func = FN_ROTATE;
        [40:59]: func = FN_TRANSLATE;
        [60:66]: func = FN_SET_X;
        [67:73]: func = FN_SET_Y;
        [74:80]: func = FN_SET_Z;
        [81:86]: func = FN_RSVD5;
        [87:92]: func = FN_RSVD6;
        default: func = FN_RSVD7;
      endcase
      gap = ((n / 50) % 3 == 0) ? 0 : $urandom_range(0, 7);
      push_cmd(func, rand_delta(), rand_delta(), rand_delta(),
               rand_coord(), rand_coord(), rand_coord(), gap,
               (n == 300) || (n == 800));
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || in_valid_i || pose_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (errors == 0) begin
      $display("[euler_xyz_rotation_transform_top] OK");
    end else begin
      $display("[euler_xyz_rotation_transform_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- euler_xyz_rotation_transform_top.f -----
design/eulxyz_pkg.sv
design/eulxyz_sine_rom.sv
design/eulxyz_trig_lane.sv
design/eulxyz_matrix_merge.sv
design/euler_xyz_rotation_transform_top.sv
dv/euler_xyz_rotation_transform_top_tb.sv
